@@ rtl/teq_pkg.sv @@
// ----------------------------------------------------------------------------
// teq_pkg
// shared types and codes for the timer expiry queue
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int TIME_W = 48;
  localparam int IVL_W  = 32;
  localparam int ID_W   = 8;

  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;
  localparam logic [1:0] KIND_SUMMARY  = 2'd3;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_DUE_SCAN,
    ST_PICK_SCAN,
    ST_FIRE,
    ST_RELOAD,
    ST_SUM_SCAN,
    ST_SUMMARY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture request word
    logic       clr_scan;  // reset scan index and accumulators
    logic       step;      // process one slot
    logic [2:0] mode;      // what a step does (a state_t code)
    logic       do_add;    // write the request into the free slot
    logic       mark_done; // retire the picked slot from this tick
    logic       emit;      // drive a result word
    logic [1:0] kind;
  } teq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_tick;
    logic scan_end;   // current step is the last slot
    logic found;      // a free slot or a pending due slot was seen
  } teq_sts_t;

endpackage

@@ rtl/teq_ctrl.sv @@
// ----------------------------------------------------------------------------
// teq_ctrl
// sequencer: add scan, due scan, repeated pick scans, reload, summary
// ----------------------------------------------------------------------------
module teq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  teq_pkg::teq_sts_t sts,
  output teq_pkg::teq_cmd_t cmd
);

  teq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= teq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mode      = state_r;
    busy          = (state_r != teq_pkg::ST_IDLE);
    case (state_r)
      teq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.clr_scan = 1'b1;
          state_nxt    = teq_pkg::ST_ADD_SCAN;
        end
      end
      teq_pkg::ST_ADD_SCAN: begin
        // add: find free slot and earliest; tick: jump to due scan
        if (sts.req_tick) begin
          state_nxt = teq_pkg::ST_DUE_SCAN;
        end else begin
          cmd.step = 1'b1;
          if (sts.scan_end) begin
            cmd.emit   = 1'b1;
            cmd.kind   = sts.found ? teq_pkg::KIND_ADD_OK : teq_pkg::KIND_ADD_FULL;
            cmd.do_add = sts.found;
            state_nxt  = teq_pkg::ST_IDLE;
          end
        end
      end
      teq_pkg::ST_DUE_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          cmd.clr_scan = 1'b1;
          state_nxt    = teq_pkg::ST_PICK_SCAN;
        end
      end
      teq_pkg::ST_PICK_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          state_nxt = teq_pkg::ST_FIRE;
        end
      end
      teq_pkg::ST_FIRE: begin
        cmd.clr_scan = 1'b1;
        if (sts.found) begin
          cmd.emit      = 1'b1;
          cmd.kind      = teq_pkg::KIND_FIRED;
          cmd.mark_done = 1'b1;
          state_nxt     = teq_pkg::ST_PICK_SCAN;
        end else begin
          state_nxt = teq_pkg::ST_RELOAD;
        end
      end
      teq_pkg::ST_RELOAD: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          cmd.clr_scan = 1'b1;
          state_nxt    = teq_pkg::ST_SUM_SCAN;
        end
      end
      teq_pkg::ST_SUM_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          state_nxt = teq_pkg::ST_SUMMARY;
        end
      end
      teq_pkg::ST_SUMMARY: begin
        cmd.emit  = 1'b1;
        cmd.kind  = teq_pkg::KIND_SUMMARY;
        state_nxt = teq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = teq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/teq_dpath.sv @@
// ----------------------------------------------------------------------------
// teq_dpath
// slot tables, one-slot-per-cycle scan unit and result register
// ----------------------------------------------------------------------------
module teq_dpath #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_req_type,
  input  logic [teq_pkg::ID_W-1:0]     in_timer_id,
  input  logic [teq_pkg::TIME_W-1:0]   in_expire_time,
  input  logic [teq_pkg::IVL_W-1:0]    in_reload_interval,
  input  logic [teq_pkg::TIME_W-1:0]   in_now_time,
  input  teq_pkg::teq_cmd_t            cmd,
  output teq_pkg::teq_sts_t            sts,
  output logic                         out_valid,
  output logic [1:0]                   out_result_kind,
  output logic [teq_pkg::ID_W-1:0]     out_fired_id,
  output logic                         out_earliest_changed,
  output logic                         out_has_next,
  output logic [teq_pkg::TIME_W-1:0]   out_next_expiry,
  output logic                         out_last
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);
  localparam logic [teq_pkg::TIME_W-1:0] TMAX = '1;

  // slot storage: small register tables, one address per cycle
  logic [TIMER_SLOTS-1:0]      valid_r;
  logic [TIMER_SLOTS-1:0]      due_r;
  logic [teq_pkg::TIME_W-1:0]  exp_r [TIMER_SLOTS];
  logic [teq_pkg::IVL_W-1:0]   ivl_r [TIMER_SLOTS];
  logic [teq_pkg::ID_W-1:0]    id_r  [TIMER_SLOTS];

  logic                        req_r;
  logic [teq_pkg::ID_W-1:0]    rid_r;
  logic [teq_pkg::TIME_W-1:0]  rexp_r;
  logic [teq_pkg::IVL_W-1:0]   rivl_r;
  logic [teq_pkg::TIME_W-1:0]  now_r;

  logic [IW-1:0]               idx_r;
  logic                        found_r;
  logic [IW-1:0]               pick_r;
  logic                        any_r;
  logic [teq_pkg::TIME_W-1:0]  best_r;
  logic [teq_pkg::ID_W-1:0]    bid_r;

  logic                        cv;
  logic [teq_pkg::TIME_W-1:0]  ce;
  logic [teq_pkg::ID_W-1:0]    ci;
  logic [teq_pkg::TIME_W:0]    rsum;
  logic                        better;
  logic [teq_pkg::TIME_W-1:0]  nmin;
  logic                        nany;

  assign cv   = valid_r[idx_r];
  assign ce   = exp_r[idx_r];
  assign ci   = id_r[idx_r];
  assign rsum = {1'b0, now_r} + {17'd0, ivl_r[idx_r]};
  assign better = !found_r || (ce < best_r) || ((ce == best_r) && (ci < bid_r));

  // earliest pending including the current slot (used at end of add scan)
  always_comb begin
    nany = any_r || (cv);
    nmin = best_r;
    if (cv && (!any_r || ce < best_r)) begin
      nmin = ce;
    end
  end

  assign sts.req_tick = req_r;
  assign sts.scan_end = (idx_r == LAST_IDX);
  assign sts.found    = found_r || (cmd.mode == teq_pkg::ST_ADD_SCAN && !cv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      due_r     <= '0;
      out_valid <= 1'b0;
      idx_r     <= '0;
      found_r   <= 1'b0;
      any_r     <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.load) begin
        req_r  <= in_req_type;
        rid_r  <= in_timer_id;
        rexp_r <= in_expire_time;
        rivl_r <= in_reload_interval;
        now_r  <= in_now_time;
      end
      if (cmd.step) begin
        if (!cmd.clr_scan) begin
          idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        end
        case (cmd.mode)
          teq_pkg::ST_ADD_SCAN: begin
            if (!cv && !found_r) begin
              found_r <= 1'b1;
              pick_r  <= idx_r;
            end
            if (cv && (!any_r || ce < best_r)) begin
              best_r <= ce;
            end
            if (cv) begin
              any_r <= 1'b1;
            end
          end
          teq_pkg::ST_DUE_SCAN: begin
            due_r[idx_r] <= cv && (ce <= now_r);
          end
          teq_pkg::ST_PICK_SCAN: begin
            if (due_r[idx_r] && better) begin
              found_r <= 1'b1;
              pick_r  <= idx_r;
              best_r  <= ce;
              bid_r   <= ci;
            end
          end
          teq_pkg::ST_RELOAD: begin
            // due flags are spent by the pick loop; slots are unchanged since the due scan
            if (cv && (ce <= now_r)) begin
              if (ivl_r[idx_r] != '0) begin
                exp_r[idx_r] <= rsum[teq_pkg::TIME_W] ? TMAX : rsum[teq_pkg::TIME_W-1:0];
              end else begin
                valid_r[idx_r] <= 1'b0;
              end
            end
          end
          teq_pkg::ST_SUM_SCAN: begin
            if (cv && (!any_r || ce < best_r)) begin
              best_r <= ce;
            end
            if (cv) begin
              any_r <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.clr_scan) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        any_r   <= 1'b0;
      end
      if (cmd.do_add) begin
        valid_r[sts.found && !found_r ? idx_r : pick_r] <= 1'b1;
        exp_r[sts.found && !found_r ? idx_r : pick_r]   <= rexp_r;
        ivl_r[sts.found && !found_r ? idx_r : pick_r]   <= rivl_r;
        id_r[sts.found && !found_r ? idx_r : pick_r]    <= rid_r;
      end
      if (cmd.mark_done) begin
        due_r[pick_r] <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result_kind      <= cmd.kind;
      out_fired_id         <= '0;
      out_earliest_changed <= 1'b0;
      out_has_next         <= 1'b0;
      out_next_expiry      <= '0;
      out_last             <= 1'b1;
      case (cmd.kind)
        teq_pkg::KIND_ADD_OK: begin
          out_earliest_changed <= !nany || (rexp_r < nmin);
          out_has_next         <= 1'b1;
          out_next_expiry      <= (!nany || rexp_r < nmin) ? rexp_r : nmin;
        end
        teq_pkg::KIND_ADD_FULL: begin
          out_has_next    <= nany;
          out_next_expiry <= nany ? nmin : '0;
        end
        teq_pkg::KIND_FIRED: begin
          out_fired_id <= bid_r;
          out_last     <= 1'b0;
        end
        teq_pkg::KIND_SUMMARY: begin
          out_has_next    <= any_r;
          out_next_expiry <= any_r ? best_r : '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/timer_expiry_queue.sv @@
// ----------------------------------------------------------------------------
// timer_expiry_queue
// bounded timer table with add and tick requests
// ----------------------------------------------------------------------------
// channel  ports                                   handshake
// in       in_req_type .. in_now_time              start high, busy low
// out      out_result_kind .. out_last             out_valid, one cycle
//
// add: one scan over all slots, one slot per cycle through the scan unit
// tick: a due scan, then a pick scan over all slots for each fired timer,
//   since each fired word needs its own pick scan, then reload and summary scans
// reset clears valid bits and the sequencer; slot payload needs none
// the receiver cannot stall: each word is shown for one cycle only
module timer_expiry_queue #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [teq_pkg::ID_W-1:0]    in_timer_id,
  input  logic [teq_pkg::TIME_W-1:0]  in_expire_time,
  input  logic [teq_pkg::IVL_W-1:0]   in_reload_interval,
  input  logic [teq_pkg::TIME_W-1:0]  in_now_time,
  output logic                        out_valid,
  output logic [1:0]                  out_result_kind,
  output logic [teq_pkg::ID_W-1:0]    out_fired_id,
  output logic                        out_earliest_changed,
  output logic                        out_has_next,
  output logic [teq_pkg::TIME_W-1:0]  out_next_expiry,
  output logic                        out_last
);

  teq_pkg::teq_cmd_t cmd;   // sequencer commands
  teq_pkg::teq_sts_t sts;   // scan status back to the sequencer

  teq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  teq_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_req_type          (in_req_type),
    .in_timer_id          (in_timer_id),
    .in_expire_time       (in_expire_time),
    .in_reload_interval   (in_reload_interval),
    .in_now_time          (in_now_time),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_result_kind      (out_result_kind),
    .out_fired_id         (out_fired_id),
    .out_earliest_changed (out_earliest_changed),
    .out_has_next         (out_has_next),
    .out_next_expiry      (out_next_expiry),
    .out_last             (out_last)
  );

endmodule

@@ rtl/teq_checker.sv @@
// ----------------------------------------------------------------------------
// teq_checker
// port-level checks on the timer expiry queue
// ----------------------------------------------------------------------------
module teq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_result_kind,
  input logic        out_earliest_changed,
  input logic        out_has_next,
  input logic        out_last
);

  // an accepted item always makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // fired words are never last, all other kinds are
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_result_kind != teq_pkg::KIND_FIRED)))
    else $error("last flag wrong");

  // a new earliest only comes with an accepted add
  a_chg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_earliest_changed) |-> (out_result_kind == teq_pkg::KIND_ADD_OK))
    else $error("earliest_changed on wrong kind");

  // an accepted add leaves the table non-empty
  a_has: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == teq_pkg::KIND_ADD_OK) |-> out_has_next)
    else $error("add left table empty");

  // no words while idle, apart from the final word registered before busy falls
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> !out_valid) else $error("word while idle");

endmodule

bind timer_expiry_queue teq_checker u_teq_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_result_kind      (out_result_kind),
  .out_earliest_changed (out_earliest_changed),
  .out_has_next         (out_has_next),
  .out_last             (out_last)
);
